FILE: hw/rtl/ocsc_pkg.sv
// Shared types for the column occlusion span clipper.
`default_nettype none

package ocsc_pkg;

  // Scan sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  // Input item kinds (in_tuser).
  localparam logic KIND_CLEAR = 1'b0;
  localparam logic KIND_CLIP  = 1'b1;

  // Stream word widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // Control broadcast to the column ring.
  typedef struct packed {
    logic clear;  // open every column
    logic shift;  // rotate the ring by one column
    logic wb;     // bit written back into the tail cell on a shift
  } ring_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ocsc_cell.sv
// One column cell: holds a solid bit and passes it to its neighbor on a shift.
`default_nettype none

module ocsc_cell
  import ocsc_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  ring_ctrl_t ctrl,
  input  wire        bit_in,
  output logic       bit_out
);

  logic solid_r;
  logic solid_nxt;

  always_comb begin
    solid_nxt = solid_r;
    if (ctrl.clear) begin
      solid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      solid_nxt = bit_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r <= 1'b0;
    end else begin
      solid_r <= solid_nxt;
    end
  end

  assign bit_out = solid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ocsc_ring.sv
// Circular chain of column cells; cell 0 is the head seen by the sequencer.
`default_nettype none

module ocsc_ring
  import ocsc_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128
) (
  input  wire        clk,
  input  wire        rst_n,
  input  ring_ctrl_t ctrl,
  output logic       head_bit
);

  logic [SCREEN_COLUMNS-1:0] bits;

  for (genvar i = 0; i < SCREEN_COLUMNS; i++) begin : g_cell
    logic nb;
    if (i == SCREEN_COLUMNS - 1) begin : g_tail
      assign nb = ctrl.wb;
    end else begin : g_mid
      assign nb = bits[i+1];
    end
    ocsc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .bit_in  (nb),
      .bit_out (bits[i])
    );
  end

  assign head_bit = bits[0];

endmodule

`default_nettype wire

FILE: hw/rtl/column_occlusion_span_clipper_top.sv
// Top level of the column occlusion span clipper: scan sequencer and stream ports.
`default_nettype none

// One solid bit per screen column lives in a ring of SCREEN_COLUMNS cells.
// A clear word (tuser 0) opens every column and returns nothing.
// A clip word (tuser 1) names [first_col, last_col); last_col saturates at
// SCREEN_COLUMNS. An empty range is retired without a scan. Otherwise the
// ring rotates one column per cycle through a full revolution, stalling only
// while a finished run has nowhere to go; a flush state then hands out the
// held run before the sequencer returns to idle.
// Each maximal open run in range comes out as one word {run_end, run_start},
// with tlast on the last run of the item; when solid is set the run's columns
// are written back solid as they pass the head. A run is held one word behind
// so the last one can be tagged. in_tready is high only while no clip is in
// progress; the output register lets the final run wait while the next word
// is accepted.

module column_occlusion_span_clipper_top
  import ocsc_pkg::*;
#(
  parameter int SCREEN_COLUMNS = 128
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // input stream
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [IN_TDATA_W-1:0]   in_tdata,   // [7:0] first_col, [15:8] last_col, [16] solid
  input  wire                    in_tuser,   // [0] kind: 0 clear, 1 clip
  // result stream
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [6:0] run_start, [13:7] run_end
  output logic                   out_tlast   // last run of the item
);

  localparam int CW = $clog2(SCREEN_COLUMNS);
  localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLUMNS - 1);
  localparam logic [7:0]    COLS8    = 8'(SCREEN_COLUMNS);

  // Input fields
  logic [7:0] in_first;
  logic [7:0] in_last;
  logic       in_solid;
  logic [7:0] in_hi_sat;
  logic       in_acc;

  assign in_first  = in_tdata[7:0];
  assign in_last   = in_tdata[15:8];
  assign in_solid  = in_tdata[16];
  assign in_hi_sat = (in_last > COLS8) ? COLS8 : in_last;
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer state
  state_t        state_r,      state_nxt;
  logic [CW-1:0] cnt_r,        cnt_nxt;      // column now at the ring head
  logic [7:0]    lo_r,         lo_nxt;
  logic [7:0]    hi_r,         hi_nxt;
  logic          mark_r,       mark_nxt;
  logic          in_run_r,     in_run_nxt;
  logic [CW-1:0] start_r,      start_nxt;
  // one run held back so the last one can carry tlast
  logic          pend_valid_r, pend_valid_nxt;
  logic [CW-1:0] pend_start_r, pend_start_nxt;
  logic [CW-1:0] pend_end_r,   pend_end_nxt;
  // output register
  logic          out_valid_r,  out_valid_nxt;
  logic [CW-1:0] out_start_r,  out_start_nxt;
  logic [CW-1:0] out_end_r,    out_end_nxt;
  logic          out_last_r,   out_last_nxt;

  ring_ctrl_t ring_ctrl;
  logic       head_bit;

  ocsc_ring #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ring_ctrl),
    .head_bit (head_bit)
  );

  // Column classification at the head
  logic          in_range;
  logic          col_open;
  logic          at_end;
  logic          run_close;
  logic          run_done;
  logic [CW-1:0] run_s;
  logic [CW-1:0] run_e;
  logic          slot_free;

  always_comb begin
    in_range  = (8'(cnt_r) >= lo_r) && (8'(cnt_r) < hi_r);
    col_open  = in_range && !head_bit;
    at_end    = (cnt_r == LAST_COL);
    run_close = in_run_r && !col_open;          // run ended on the previous column
    run_done  = run_close || (col_open && at_end);
    run_s     = in_run_r ? start_r : cnt_r;
    run_e     = run_close ? (cnt_r - CW'(1)) : cnt_r;
    slot_free = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mark_nxt       = mark_r;
    in_run_nxt     = in_run_r;
    start_nxt      = start_r;
    pend_valid_nxt = pend_valid_r;
    pend_start_nxt = pend_start_r;
    pend_end_nxt   = pend_end_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_last_nxt   = out_last_r;
    ring_ctrl      = '0;
    in_tready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (in_tuser == KIND_CLEAR) begin
            ring_ctrl.clear = 1'b1;
          end else if (in_first < in_hi_sat) begin
            lo_nxt     = in_first;
            hi_nxt     = in_hi_sat;
            mark_nxt   = in_solid;
            in_run_nxt = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // stall the ring only when a finished run has nowhere to go
        if (!(run_done && pend_valid_r && !slot_free)) begin
          ring_ctrl.shift = 1'b1;
          ring_ctrl.wb    = head_bit | (col_open & mark_r);
          if (run_done) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_start_nxt = pend_start_r;
              out_end_nxt   = pend_end_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_start_nxt = run_s;
            pend_end_nxt   = run_e;
          end
          if (col_open && !in_run_r) begin
            start_nxt = cnt_r;
          end
          in_run_nxt = col_open && !at_end;
          if (at_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_FLUSH;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_start_nxt  = pend_start_r;
          out_end_nxt    = pend_end_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      in_run_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      in_run_r     <= in_run_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mark_r       <= mark_nxt;
    start_r      <= start_nxt;
    pend_start_r <= pend_start_nxt;
    pend_end_r   <= pend_end_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, 7'(out_end_r), 7'(out_start_r)};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Head must be back at column 0 whenever a new word can be taken.
  a_idle_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (cnt_r == '0 && !pend_valid_r && !in_run_r))
    else $error("sequencer idle with scan state left over");

  // An open run is only tracked while scanning.
  a_run_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> (state_r == ST_SCAN))
    else $error("open run outside of scan");

  // Emitted runs are well ordered.
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_start_r <= out_end_r))
    else $error("run start beyond run end");

  // The ring never rotates while a stalled run waits for the output.
  a_no_lost_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_ctrl.shift && run_done && pend_valid_r) |-> slot_free)
    else $error("run overwritten while output busy");
`endif

endmodule

`default_nettype wire
